@@ hdl/hfr_pkg.sv @@
// Package for the heartbeat frame receiver: frame constants, status codes,
// result record type. No dependencies.
`timescale 1ns / 1ps

package hfr_pkg;

  localparam logic [7:0] FrameStart    = 8'h7E;
  localparam logic [7:0] FrameTail     = 8'hE7;
  localparam logic [7:0] FrameLength   = 8'h12;
  localparam logic [7:0] FrameProtocol = 8'hC0;
  localparam logic [7:0] AddrReset     = 8'h01;

  localparam int unsigned PosW         = 5;
  localparam int unsigned CapIdxW      = 4;
  localparam int unsigned FrameBytes   = 22;
  localparam int unsigned CaptureFirst = 4;
  localparam int unsigned CaptureDepth = 14;

  localparam logic [PosW-1:0] PosHunt  = PosW'(0);
  localparam logic [PosW-1:0] PosLen   = PosW'(1);
  localparam logic [PosW-1:0] PosProt  = PosW'(2);
  localparam logic [PosW-1:0] PosAddr  = PosW'(3);
  localparam logic [PosW-1:0] PosFirst = PosW'(CaptureFirst);
  localparam logic [PosW-1:0] PosEnd   = PosW'(CaptureFirst + CaptureDepth);
  localparam logic [PosW-1:0] PosTail  = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] PosLimit = PosW'(FrameBytes);

  // capture slots, status byte first
  localparam int unsigned CapFault  = 0;
  localparam int unsigned CapWMode  = 1;
  localparam int unsigned CapWParam = 2;
  localparam int unsigned CapGMode  = 3;
  localparam int unsigned CapGParam = 4;
  localparam int unsigned CapTMode  = 5;
  localparam int unsigned CapHAng   = 6;
  localparam int unsigned CapVAng   = 8;
  localparam int unsigned CapHSpd   = 10;
  localparam int unsigned CapVSpd   = 12;

  typedef enum logic [1:0] {
    StGood      = 2'd0,
    StBadTail   = 2'd1,
    StBadHeader = 2'd2
  } status_e;

  typedef struct packed {
    status_e            frame_status;
    logic [7:0]         device_fault;
    logic [7:0]         white_lamp_mode;
    logic [7:0]         white_lamp_param;
    logic [7:0]         green_lamp_mode;
    logic [7:0]         green_lamp_param;
    logic [7:0]         table_mode;
    logic signed [15:0] horizontal_angle;
    logic signed [15:0] vertical_angle;
    logic [15:0]        horizontal_speed;
    logic [15:0]        vertical_speed;
    logic               angle_changed;
  } result_t;

endpackage

@@ hdl/hfr_if.sv @@
// Channel interfaces: serial byte beats in, decoded frame beats out.
// Depends on nothing; widths follow the frame format.
`timescale 1ns / 1ps

interface hfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hfr_frame_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [7:0]         device_fault;
  logic [7:0]         white_lamp_mode;
  logic [7:0]         white_lamp_param;
  logic [7:0]         green_lamp_mode;
  logic [7:0]         green_lamp_param;
  logic [7:0]         table_mode;
  logic signed [15:0] horizontal_angle;
  logic signed [15:0] vertical_angle;
  logic [15:0]        horizontal_speed;
  logic [15:0]        vertical_speed;
  logic               angle_changed;

  modport source (
    output valid, output frame_status, output device_fault,
    output white_lamp_mode, output white_lamp_param,
    output green_lamp_mode, output green_lamp_param, output table_mode,
    output horizontal_angle, output vertical_angle,
    output horizontal_speed, output vertical_speed, output angle_changed,
    input ready
  );
  modport sink (
    input valid, input frame_status, input device_fault,
    input white_lamp_mode, input white_lamp_param,
    input green_lamp_mode, input green_lamp_param, input table_mode,
    input horizontal_angle, input vertical_angle,
    input horizontal_speed, input vertical_speed, input angle_changed,
    output ready
  );
endinterface

@@ hdl/hfr_in_reg.sv @@
// Input register: holds one received byte beat until the parser takes it.
// No package dependencies.
`timescale 1ns / 1ps

module hfr_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] byte_o,
  input  logic       consume_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ hdl/hfr_parser.sv @@
// Frame parser: byte position, field capture, last angles, result decode.
// Depends on hfr_pkg.
`timescale 1ns / 1ps

module hfr_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [7:0]     byte_i,
  input  logic [7:0]     dev_addr_i,
  input  logic           out_free_i,
  output logic           consume_o,
  output logic           emit_o,
  output hfr_pkg::result_t result_o
);
  import hfr_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [7:0]         cap_q [CaptureDepth];
  logic [15:0]        last_h_q, last_v_q;
  logic               hunting, bad_hdr, at_tail, emit, cap_we;
  logic [CapIdxW-1:0] cap_idx;
  logic [15:0]        h_ang, v_ang;

  assign hunting = (pos_q == PosHunt) || (pos_q >= PosLimit);
  assign bad_hdr = ((pos_q == PosLen)  && (byte_i != FrameLength))
                || ((pos_q == PosProt) && (byte_i != FrameProtocol))
                || ((pos_q == PosAddr) && (byte_i != dev_addr_i));
  assign at_tail = (pos_q == PosTail);
  assign emit    = !hunting && (bad_hdr || at_tail);

  assign consume_o = valid_i && (!emit || out_free_i);
  assign emit_o    = emit;

  assign cap_idx = CapIdxW'(pos_q - PosFirst);
  assign cap_we  = consume_o && !hunting && !bad_hdr
                && (pos_q >= PosFirst) && (pos_q < PosEnd);

  always_comb begin
    pos_d = pos_q;
    if (hunting) begin
      pos_d = (byte_i == FrameStart) ? PosLen : PosHunt;
    end else if (bad_hdr || at_tail) begin
      pos_d = PosHunt;
    end else begin
      pos_d = pos_q + PosW'(1);
    end
  end

  assign h_ang = {cap_q[CapHAng], cap_q[CapHAng+1]};
  assign v_ang = {cap_q[CapVAng], cap_q[CapVAng+1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosHunt;
      last_h_q <= '0;
      last_v_q <= '0;
    end else if (consume_o) begin
      pos_q <= pos_d;
      if (at_tail && (byte_i == FrameTail)) begin
        last_h_q <= h_ang;
        last_v_q <= v_ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      cap_q[cap_idx] <= byte_i;
    end
  end

  always_comb begin
    result_o = '0;
    if (bad_hdr) begin
      result_o.frame_status = StBadHeader;
    end else if (byte_i != FrameTail) begin
      result_o.frame_status = StBadTail;
    end else begin
      result_o.frame_status     = StGood;
      result_o.device_fault     = cap_q[CapFault];
      result_o.white_lamp_mode  = cap_q[CapWMode];
      result_o.white_lamp_param = cap_q[CapWParam];
      result_o.green_lamp_mode  = cap_q[CapGMode];
      result_o.green_lamp_param = cap_q[CapGParam];
      result_o.table_mode       = cap_q[CapTMode];
      result_o.horizontal_angle = h_ang;
      result_o.vertical_angle   = v_ang;
      result_o.horizontal_speed = {cap_q[CapHSpd], cap_q[CapHSpd+1]};
      result_o.vertical_speed   = {cap_q[CapVSpd], cap_q[CapVSpd+1]};
      result_o.angle_changed    = (h_ang != last_h_q) || (v_ang != last_v_q);
    end
  end

endmodule

@@ hdl/hfr_result_reg.sv @@
// Result register: holds one decoded frame beat until the sink takes it.
// Depends on hfr_pkg.
`timescale 1ns / 1ps

module hfr_result_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hfr_pkg::result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output hfr_pkg::result_t result_o
);
  import hfr_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ hdl/heartbeat_frame_receiver_core.sv @@
// Top level of the heartbeat frame receiver: input register, parser, result
// register and the device address register. Depends on hfr_pkg, hfr_if.
//
//   channel  dir  beat                    accepted when
//   rx_i     in   one serial byte         rx_i.valid && rx_i.ready
//   frame_o  out  one decoded frame       frame_o.valid && frame_o.ready
//   cfg      in   device address, 8 bits  cfg_we_i high
//
// One byte per cycle sustained while frame_o is not stalled. A byte waits in
// the input register, then the parser decides it; a result shows on frame_o
// the cycle after. rx_i.ready drops only when a byte that ends a frame waits
// for a result register that is full and stalled. Reset clears the position,
// the last angles, the valid flags and sets the device address to 1.
`timescale 1ns / 1ps

module heartbeat_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hfr_byte_if.sink    rx_i,
  hfr_frame_if.source frame_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import hfr_pkg::*;

  logic       byte_valid, consume, emit, out_free;
  logic [7:0] byte_q;
  logic [7:0] dev_addr_q;
  result_t    parse_res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= AddrReset;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  hfr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .byte_i    (rx_i.rx_byte),
    .ready_o   (rx_i.ready),
    .valid_o   (byte_valid),
    .byte_o    (byte_q),
    .consume_i (consume)
  );

  hfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (byte_valid),
    .byte_i     (byte_q),
    .dev_addr_i (dev_addr_q),
    .out_free_i (out_free),
    .consume_o  (consume),
    .emit_o     (emit),
    .result_o   (parse_res)
  );

  hfr_result_reg u_result_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (consume && emit),
    .result_i (parse_res),
    .free_o   (out_free),
    .valid_o  (frame_o.valid),
    .ready_i  (frame_o.ready),
    .result_o (out_res)
  );

  assign frame_o.frame_status     = out_res.frame_status;
  assign frame_o.device_fault     = out_res.device_fault;
  assign frame_o.white_lamp_mode  = out_res.white_lamp_mode;
  assign frame_o.white_lamp_param = out_res.white_lamp_param;
  assign frame_o.green_lamp_mode  = out_res.green_lamp_mode;
  assign frame_o.green_lamp_param = out_res.green_lamp_param;
  assign frame_o.table_mode       = out_res.table_mode;
  assign frame_o.horizontal_angle = out_res.horizontal_angle;
  assign frame_o.vertical_angle   = out_res.vertical_angle;
  assign frame_o.horizontal_speed = out_res.horizontal_speed;
  assign frame_o.vertical_speed   = out_res.vertical_speed;
  assign frame_o.angle_changed    = out_res.angle_changed;

endmodule

@@ hdl/hfr_checker.sv @@
// Port-level checks for the heartbeat frame receiver, bound to the top level.
// Depends on hfr_pkg.
`timescale 1ns / 1ps

module hfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready_i,
  input logic        frame_valid_i,
  input logic        frame_ready_i,
  input logic [1:0]  frame_status_i,
  input logic [7:0]  device_fault_i,
  input logic [7:0]  table_mode_i,
  input logic [15:0] horizontal_angle_i,
  input logic [15:0] vertical_speed_i,
  input logic        angle_changed_i
);
  import hfr_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_i && !frame_ready_i |=>
      frame_valid_i && $stable(frame_status_i))
    else $error("stalled frame beat changed");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_i && (frame_status_i != StGood) |->
      (device_fault_i == 8'd0) && (table_mode_i == 8'd0) &&
      (horizontal_angle_i == 16'd0) && (vertical_speed_i == 16'd0) &&
      !angle_changed_i)
    else $error("error beat carries nonzero fields");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_i |-> frame_valid_i && !frame_ready_i)
    else $error("byte input stalled without output stall");

endmodule

bind heartbeat_frame_receiver_core hfr_checker u_hfr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rx_ready_i         (rx_i.ready),
  .frame_valid_i      (frame_o.valid),
  .frame_ready_i      (frame_o.ready),
  .frame_status_i     (frame_o.frame_status),
  .device_fault_i     (frame_o.device_fault),
  .table_mode_i       (frame_o.table_mode),
  .horizontal_angle_i (frame_o.horizontal_angle),
  .vertical_speed_i   (frame_o.vertical_speed),
  .angle_changed_i    (frame_o.angle_changed)
);
